[sv/bcgu_pkg.sv]
// Package: shared types, constants and fixed-point helpers for the gradient update block.
`timescale 1ns / 1ps

package bcgu_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] Q_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN   = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [2:0] {
        MODE_STEP   = 3'd0,
        MODE_SCALED = 3'd1,
        MODE_ELEM   = 3'd2,
        MODE_L1     = 3'd3,
        MODE_L2     = 3'd4,
        MODE_SET    = 3'd5,
        MODE_ADD    = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE         = 3'd0,
        REG_LRATE        = 3'd1,
        REG_COEFF        = 3'd2,
        REG_OFFSET_B     = 3'd3,
        REG_DECAY_RATE   = 3'd4,
        REG_LOWER_BOUND  = 3'd5,
        REG_UPPER_BOUND  = 3'd6,
        REG_CLAMP_ENABLE = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] param_in;
        logic signed [31:0] direction;
        logic signed [31:0] elem_step;
        logic               last_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] param_out;
        logic               clipped;
        logic               run_hit;
        logic               last_out;
    } out_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] lrate;
        logic signed [31:0] coeff;
        logic signed [31:0] offset_b;
        logic [30:0]        decay_rate;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic               clamp_enable;
    } cfg_t;

    // front half -> back half
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] p;
        logic signed [31:0] d;
        logic signed [31:0] m2;    // full step (modes 1,2), d+wd*p (mode 4), delta (mode 3)
        logic               last;
    } mid_t;

    // back half -> output stage
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] v;
        logic signed [31:0] delta;
        logic               gt;
        logic               lt;
        logic               last;
    } fin_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] sum;
        sum = {a[31], a} + {b[31], b};
        if (sum[32] != sum[31])
            return sum[32] ? S32_MIN : S32_MAX;
        return sum[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] dif;
        dif = {a[31], a} - {b[31], b};
        if (dif[32] != dif[31])
            return dif[32] ? S32_MIN : S32_MAX;
        return dif[31:0];
    endfunction

    // Floor shift of a full product, saturated to 32 bits.
    function automatic logic signed [31:0] q_scale(input logic signed [63:0] prod);
        logic signed [63:0] sh;
        sh = prod >>> FRAC_BITS;
        if (sh > Q_MAX)
            return S32_MAX;
        if (sh < Q_MIN)
            return S32_MIN;
        return sh[31:0];
    endfunction

endpackage

[sv/bcgu_front.sv]
// Front half: first multiplier stage and the scale/offset add stage.
`timescale 1ns / 1ps

module bcgu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  bcgu_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  bcgu_pkg::in_t       in_data,
    output logic                in_rdy,
    output logic                out_valid,
    output bcgu_pkg::mid_t      out_data,
    input  logic                out_rdy
);

    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic [2:0]          s1_mode_reg;
    logic signed [31:0]  s1_p_reg;
    logic signed [31:0]  s1_d_reg;
    logic                s1_last_reg;
    logic signed [63:0]  s1_prod_reg;
    logic signed [63:0]  s1_prod_next;
    bcgu_pkg::mid_t      s2_reg;
    bcgu_pkg::mid_t      s2_next;

    logic                s1_adv;
    logic                s2_adv;
    logic signed [31:0]  abs_s;
    logic signed [31:0]  wd_s;
    logic signed [31:0]  op_a;
    logic signed [31:0]  op_b;
    logic signed [31:0]  qa;
    logic signed [31:0]  addend;

    assign s2_adv = !s2_valid_reg || out_rdy;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign in_rdy = s1_adv;

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    assign wd_s  = $signed({1'b0, cfg.decay_rate});
    assign abs_s = (cfg.lrate == bcgu_pkg::S32_MIN) ? bcgu_pkg::S32_MAX :
                   (cfg.lrate < 0) ? -cfg.lrate : cfg.lrate;

    // Operand select for the first product.
    always_comb
    begin
        unique case (cfg.mode)
            bcgu_pkg::MODE_SCALED:
            begin
                op_a = cfg.lrate;
                op_b = cfg.coeff;
            end
            bcgu_pkg::MODE_ELEM:
            begin
                op_a = in_data.elem_step;
                op_b = cfg.coeff;
            end
            bcgu_pkg::MODE_L1:
            begin
                op_a = abs_s;
                op_b = wd_s;
            end
            bcgu_pkg::MODE_L2:
            begin
                op_a = wd_s;
                op_b = in_data.param_in;
            end
            default:
            begin
                op_a = cfg.lrate;
                op_b = cfg.coeff;
            end
        endcase
        s1_prod_next = op_a * op_b;
    end

    // Scale, then add direction (mode 4), nothing (mode 3) or offset (others).
    always_comb
    begin
        qa      = bcgu_pkg::q_scale(s1_prod_reg);
        addend  = (s1_mode_reg == bcgu_pkg::MODE_L2) ? s1_d_reg : cfg.offset_b;
        s2_next.mode = s1_mode_reg;
        s2_next.p    = s1_p_reg;
        s2_next.d    = s1_d_reg;
        s2_next.last = s1_last_reg;
        s2_next.m2   = (s1_mode_reg == bcgu_pkg::MODE_L1) ? qa : bcgu_pkg::sat_add(qa, addend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_mode_reg <= cfg.mode;
            s1_p_reg    <= in_data.param_in;
            s1_d_reg    <= in_data.direction;
            s1_last_reg <= in_data.last_in;
            s1_prod_reg <= s1_prod_next;
        end
        if (s2_adv && s1_valid_reg)
            s2_reg <= s2_next;
    end

endmodule

[sv/bcgu_back.sv]
// Back half: second multiplier stage and the parameter add stage.
`timescale 1ns / 1ps

module bcgu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bcgu_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  bcgu_pkg::mid_t      in_data,
    output logic                in_rdy,
    output logic                out_valid,
    output bcgu_pkg::fin_t      out_data,
    input  logic                out_rdy
);

    logic                s3_valid_reg;
    logic                s4_valid_reg;
    logic [2:0]          s3_mode_reg;
    logic signed [31:0]  s3_p_reg;
    logic signed [31:0]  s3_d_reg;
    logic signed [31:0]  s3_delta_reg;
    logic                s3_gt_reg;
    logic                s3_lt_reg;
    logic                s3_last_reg;
    logic signed [63:0]  s3_prod_reg;
    logic signed [63:0]  s3_prod_next;
    bcgu_pkg::fin_t      s4_reg;
    bcgu_pkg::fin_t      s4_next;

    logic                s3_adv;
    logic                s4_adv;
    logic signed [31:0]  op_a;
    logic signed [31:0]  op_b;
    logic signed [32:0]  p_ext;
    logic signed [32:0]  delta_ext;
    logic                gt_next;
    logic                lt_next;
    logic signed [31:0]  qb;

    assign s4_adv = !s4_valid_reg || out_rdy;
    assign s3_adv = !s3_valid_reg || s4_adv;
    assign in_rdy = s3_adv;

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

    always_comb
    begin
        op_a = ((in_data.mode == bcgu_pkg::MODE_SCALED) || (in_data.mode == bcgu_pkg::MODE_ELEM))
               ? in_data.m2 : cfg.lrate;
        op_b = (in_data.mode == bcgu_pkg::MODE_L2) ? in_data.m2 : in_data.d;
        s3_prod_next = op_a * op_b;
        // soft-threshold window, delta is never negative
        p_ext     = {in_data.p[31], in_data.p};
        delta_ext = {in_data.m2[31], in_data.m2};
        gt_next   = p_ext > delta_ext;
        lt_next   = p_ext < -delta_ext;
    end

    always_comb
    begin
        qb = bcgu_pkg::q_scale(s3_prod_reg);
        s4_next.mode  = s3_mode_reg;
        s4_next.delta = s3_delta_reg;
        s4_next.gt    = s3_gt_reg;
        s4_next.lt    = s3_lt_reg;
        s4_next.last  = s3_last_reg;
        unique case (s3_mode_reg)
            bcgu_pkg::MODE_STEP,
            bcgu_pkg::MODE_SCALED,
            bcgu_pkg::MODE_ELEM,
            bcgu_pkg::MODE_L1,
            bcgu_pkg::MODE_L2:  s4_next.v = bcgu_pkg::sat_add(s3_p_reg, qb);
            bcgu_pkg::MODE_SET: s4_next.v = s3_d_reg;
            bcgu_pkg::MODE_ADD: s4_next.v = bcgu_pkg::sat_add(s3_p_reg, s3_d_reg);
            default:            s4_next.v = s3_p_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_adv)
                s3_valid_reg <= in_valid;
            if (s4_adv)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv && in_valid)
        begin
            s3_mode_reg  <= in_data.mode;
            s3_p_reg     <= in_data.p;
            s3_d_reg     <= in_data.d;
            s3_delta_reg <= in_data.m2;
            s3_gt_reg    <= gt_next;
            s3_lt_reg    <= lt_next;
            s3_last_reg  <= in_data.last;
            s3_prod_reg  <= s3_prod_next;
        end
        if (s4_adv && s3_valid_reg)
            s4_reg <= s4_next;
    end

endmodule

[sv/bcgu_out.sv]
// Output stage: soft threshold, box clamp, run hit flag and output register.
`timescale 1ns / 1ps

module bcgu_out (
    input  logic                clk,
    input  logic                rst_n,
    input  bcgu_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  bcgu_pkg::fin_t      in_data,
    output logic                in_rdy,
    output logic                out_valid,
    output bcgu_pkg::out_t      out_data,
    input  logic                out_rdy
);

    logic                s5_valid_reg;
    bcgu_pkg::out_t      s5_reg;
    bcgu_pkg::out_t      s5_next;
    logic                hit_reg;
    logic                hit_next;
    logic                s5_adv;
    logic                load;
    logic                clampable;
    logic signed [31:0]  v;
    logic                clip;

    assign s5_adv = !s5_valid_reg || out_rdy;
    assign in_rdy = s5_adv;
    assign load   = s5_adv && in_valid;

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_reg;

    always_comb
    begin
        clampable = cfg.clamp_enable &&
                    (in_data.mode == bcgu_pkg::MODE_STEP   ||
                     in_data.mode == bcgu_pkg::MODE_SCALED ||
                     in_data.mode == bcgu_pkg::MODE_ELEM   ||
                     in_data.mode == bcgu_pkg::MODE_SET    ||
                     in_data.mode == bcgu_pkg::MODE_ADD);
        v    = in_data.v;
        clip = 1'b0;
        if (in_data.mode == bcgu_pkg::MODE_L1)
        begin
            priority if (in_data.gt)
                v = bcgu_pkg::sat_sub(in_data.v, in_data.delta);
            else if (in_data.lt)
                v = bcgu_pkg::sat_add(in_data.v, in_data.delta);
            else
                v = '0;
        end
        else if (clampable)
        begin
            // lower bound tested first: wins only for values below it
            if (in_data.v < cfg.lower_bound)
            begin
                v    = cfg.lower_bound;
                clip = 1'b1;
            end
            else if (in_data.v > cfg.upper_bound)
            begin
                v    = cfg.upper_bound;
                clip = 1'b1;
            end
        end
        s5_next.param_out = v;
        s5_next.clipped   = clip;
        s5_next.run_hit   = hit_reg | clip;
        s5_next.last_out  = in_data.last;
        hit_next = in_data.last ? 1'b0 : (hit_reg | clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (s5_adv)
                s5_valid_reg <= in_valid;
            if (load)
                hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s5_reg <= s5_next;
    end

endmodule

[sv/box_clamped_gradient_update_top.sv]
// Top level of the box-clamped gradient update pipeline.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ----------------------------------
//  in        into block in_valid / in_stall  bcgu_pkg::in_t  (element + grad)
//  out       from block out_valid/ out_stall bcgu_pkg::out_t (updated element)
//  cfg       into block cfg_we               cfg_index, cfg_data (write only)
//
//  One transaction per cycle sustained while out is not stalled; a result
//  passes five register stages on its way: two multiplier stages, each
//  followed by a scale/add stage, then the threshold/clamp stage that drives
//  the output register.
//  rst_n clears all stage valid bits, the run hit flag and the registers to
//  their defaults (coeff 1.0, bounds at the full range).
//  Each stage advances when it is empty or the one after it advances, so a
//  stall on out collapses bubbles first and back-pressures in only when full.
//  Write configuration only while the pipeline is empty.

module box_clamped_gradient_update_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bcgu_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output bcgu_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    bcgu_pkg::cfg_t  cfg_reg;
    bcgu_pkg::mid_t  mid_data;
    bcgu_pkg::fin_t  fin_data;
    logic            front_rdy;
    logic            mid_valid;
    logic            mid_rdy;
    logic            fin_valid;
    logic            fin_rdy;

    // Configuration registers: one write per enabled cycle, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= bcgu_pkg::MODE_STEP;
            cfg_reg.lrate        <= '0;
            cfg_reg.coeff        <= 32'sh0001_0000;
            cfg_reg.offset_b     <= '0;
            cfg_reg.decay_rate   <= '0;
            cfg_reg.lower_bound  <= bcgu_pkg::S32_MIN;
            cfg_reg.upper_bound  <= bcgu_pkg::S32_MAX;
            cfg_reg.clamp_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (bcgu_pkg::reg_idx_t'(cfg_index))
                bcgu_pkg::REG_MODE:         cfg_reg.mode         <= bcgu_pkg::mode_t'(cfg_data[2:0]);
                bcgu_pkg::REG_LRATE:        cfg_reg.lrate        <= cfg_data;
                bcgu_pkg::REG_COEFF:        cfg_reg.coeff        <= cfg_data;
                bcgu_pkg::REG_OFFSET_B:     cfg_reg.offset_b     <= cfg_data;
                bcgu_pkg::REG_DECAY_RATE:   cfg_reg.decay_rate   <= cfg_data[30:0];
                bcgu_pkg::REG_LOWER_BOUND:  cfg_reg.lower_bound  <= cfg_data;
                bcgu_pkg::REG_UPPER_BOUND:  cfg_reg.upper_bound  <= cfg_data;
                bcgu_pkg::REG_CLAMP_ENABLE: cfg_reg.clamp_enable <= cfg_data[0];
                default:                    cfg_reg.mode         <= cfg_reg.mode;
            endcase
        end
    end

    // Stages 1-2: first product, then scale and offset.
    bcgu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_rdy    (front_rdy),
        .out_valid (mid_valid),
        .out_data  (mid_data),
        .out_rdy   (mid_rdy)
    );

    // Stages 3-4: second product, then add to the parameter.
    bcgu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (mid_valid),
        .in_data   (mid_data),
        .in_rdy    (mid_rdy),
        .out_valid (fin_valid),
        .out_data  (fin_data),
        .out_rdy   (fin_rdy)
    );

    // Stage 5: threshold or clamp, hit flag, output register.
    bcgu_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (fin_valid),
        .in_data   (fin_data),
        .in_rdy    (fin_rdy),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_rdy   (!out_stall)
    );

    // Hold the input side only while stage 1 is full and cannot drain.
    assign in_stall = !front_rdy;

endmodule

[sv/bcgu_checker.sv]
// Port checker for the gradient update top level, with its bind.
`timescale 1ns / 1ps

module bcgu_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  bcgu_pkg::in_t   in_data,
    input  logic            out_valid,
    input  logic            out_stall,
    input  bcgu_pkg::out_t  out_data
);

    // Hold a stalled result steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

    // Back-pressure only when the output itself is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // A clipped element always shows in the run flag.
    a_hit_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.clipped |-> out_data.run_hit)
        else $error("clipped without run hit");

    // The run flag restarts after the last element.
    a_hit_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_out) ##1 out_valid
        |-> out_data.run_hit == out_data.clipped)
        else $error("run hit not cleared after last");

    // A clean run stays clean until something is clipped.
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_data.run_hit) ##1 (out_valid && !out_data.clipped)
        |-> !out_data.run_hit)
        else $error("run hit set without a clip");

endmodule

bind box_clamped_gradient_update_top bcgu_checker u_bcgu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[bench/tb.sv]
// Self-checking testbench for the box-clamped gradient update pipeline.
`timescale 1ns / 1ps

module tb import bcgu_pkg::*; ();

    // Code 7 of the mode register selects no update: the element passes through.
    localparam logic [2:0]         MODE_UNUSED = 3'd7;
    localparam logic signed [31:0] Q_ONE       = 32'sh0001_0000;

    // Cross-check of every updated element against an independent prediction.
    // Holds its own copy of the registers and of the run hit flag.
    class update_checker;
        logic [2:0]         mode;
        logic signed [31:0] lrate;
        logic signed [31:0] coeff;
        logic signed [31:0] offset_b;
        logic [30:0]        decay;
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic               clamp_on;
        logic               hit_accum;
        out_t               pending_updates[$];
        int                 mismatches;

        function new();
            mode        = MODE_STEP;
            lrate       = '0;
            coeff       = Q_ONE;
            offset_b    = '0;
            decay       = '0;
            lower       = S32_MIN;
            upper       = S32_MAX;
            clamp_on    = 1'b0;
            hit_accum   = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_MODE:         mode      = data[2:0];
                REG_LRATE:        lrate     = data;
                REG_COEFF:        coeff     = data;
                REG_OFFSET_B:     offset_b  = data;
                REG_DECAY_RATE:   decay     = data[30:0];
                REG_LOWER_BOUND:  lower     = data;
                REG_UPPER_BOUND:  upper     = data;
                REG_CLAMP_ENABLE: clamp_on  = data[0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clip32(logic signed [63:0] v);
            if (v > 64'sh0000_0000_7FFF_FFFF)
                return S32_MAX;
            if (v < -64'sh0000_0000_8000_0000)
                return S32_MIN;
            return v[31:0];
        endfunction

        function logic signed [31:0] fx_add(logic signed [63:0] a, logic signed [63:0] b);
            return clip32(a + b);
        endfunction

        // Full product, floor shift by the fraction width, saturate.
        function logic signed [31:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] prod;
            prod = a * b;
            return clip32(prod >>> FRAC_BITS);
        endfunction

        function out_t update_element(in_t item);
            out_t               res;
            logic signed [31:0] v;
            logic signed [31:0] full;
            logic signed [31:0] delta;
            logic signed [63:0] wide_delta;
            logic signed [63:0] abs_step;
            logic               clampable;
            logic               clip;
            v         = item.param_in;
            clampable = 1'b0;
            clip      = 1'b0;
            case (mode)
                MODE_STEP:
                begin
                    v = fx_add(item.param_in, fx_mul(lrate, item.direction));
                    clampable = 1'b1;
                end
                MODE_SCALED:
                begin
                    full = fx_add(fx_mul(lrate, coeff), offset_b);
                    v = fx_add(item.param_in, fx_mul(full, item.direction));
                    clampable = 1'b1;
                end
                MODE_ELEM:
                begin
                    full = fx_add(fx_mul(item.elem_step, coeff), offset_b);
                    v = fx_add(item.param_in, fx_mul(full, item.direction));
                    clampable = 1'b1;
                end
                MODE_L1:
                begin
                    abs_step = lrate;
                    if (abs_step < 0)
                        abs_step = -abs_step;
                    delta = fx_mul(clip32(abs_step), decay);
                    wide_delta = delta;
                    v = fx_add(item.param_in, fx_mul(lrate, item.direction));
                    if (item.param_in > wide_delta)
                        v = fx_add(v, -wide_delta);
                    else if (item.param_in < -wide_delta)
                        v = fx_add(v, wide_delta);
                    else
                        v = '0;
                end
                MODE_L2:
                    v = fx_add(item.param_in, fx_mul(lrate,
                            fx_add(item.direction, fx_mul(decay, item.param_in))));
                MODE_SET:
                begin
                    v = item.direction;
                    clampable = 1'b1;
                end
                MODE_ADD:
                begin
                    v = fx_add(item.param_in, item.direction);
                    clampable = 1'b1;
                end
                default:
                    v = item.param_in;
            endcase
            if (clampable && clamp_on) begin
                if (v < lower) begin
                    v = lower;
                    clip = 1'b1;
                end
                else if (v > upper) begin
                    v = upper;
                    clip = 1'b1;
                end
            end
            hit_accum     = hit_accum | clip;
            res.param_out = v;
            res.clipped   = clip;
            res.run_hit   = hit_accum;
            res.last_out  = item.last_in;
            if (item.last_in)
                hit_accum = 1'b0;
            return res;
        endfunction

        function void note_input(in_t item);
            pending_updates.push_back(update_element(item));
        endfunction

        function int pending();
            return pending_updates.size();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(out_t got);
            out_t want;
            if (pending_updates.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = pending_updates.pop_front();
            if (got.param_out !== want.param_out)
                report_mismatch($sformatf("param_out %h, expected %h",
                                          got.param_out, want.param_out));
            if (got.clipped !== want.clipped)
                report_mismatch($sformatf("clipped %b, expected %b", got.clipped, want.clipped));
            if (got.run_hit !== want.run_hit)
                report_mismatch($sformatf("run_hit %b, expected %b", got.run_hit, want.run_hit));
            if (got.last_out !== want.last_out)
                report_mismatch($sformatf("last_out %b, expected %b",
                                          got.last_out, want.last_out));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    update_checker checker_h;
    int            sender_idle_pct;
    int            receiver_idle_pct;

    box_clamped_gradient_update_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Draw a Q16.16 value: full-range noise, the extremes, small values around
    // zero, and moderate magnitudes that keep most products out of saturation.
    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2:
                case ($urandom_range(0, 5))
                    0: return S32_MAX;
                    1: return S32_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    4: return -Q_ONE;
                    default: return -32'sd1;
                endcase
            3, 4: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
            default: return $urandom_range(0, 32'h200_0000) - 32'h100_0000;
        endcase
    endfunction

    // Draw a register set; the mode is chosen by the caller.
    function automatic cfg_t rand_config();
        cfg_t               c;
        logic signed [31:0] a;
        logic signed [31:0] b;
        c.mode         = MODE_STEP;
        c.lrate        = rand_q() >>> $urandom_range(0, 12);
        c.coeff        = rand_q();
        c.offset_b     = rand_q();
        c.decay_rate   = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                                     : 31'($urandom_range(0, 32'h2_0000));
        a = rand_q();
        b = rand_q();
        if ($urandom_range(0, 5) == 0) begin
            a = S32_MIN;
            b = S32_MAX;
        end
        // Mostly a proper box; now and then leave the bounds crossed.
        if (a > b && $urandom_range(0, 4) != 0) begin
            c.lower_bound = b;
            c.upper_bound = a;
        end
        else begin
            c.lower_bound = a;
            c.upper_bound = b;
        end
        c.clamp_enable = ($urandom_range(0, 3) != 0);
        return c;
    endfunction

    // Present one element and hold it until the block takes it. Random idle
    // cycles go in front so that gaps land on every pipeline stage.
    task automatic send_element(input logic signed [31:0] p, input logic signed [31:0] d,
                                input logic signed [31:0] es, input logic last);
        in_t item;
        item.param_in  = p;
        item.direction = d;
        item.elem_step = es;
        item.last_in   = last;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        checker_h.note_input(item);
    endtask

    // Drop valid and hold off until every expected update has come back, then
    // give the pipeline its latency and a margin before anything else happens.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One register write; the enable drops between writes.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        checker_h.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Write every register. Unused upper data bits carry noise: the block must
    // ignore them.
    task automatic load_config(input logic [2:0] mode_code, input cfg_t c);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(REG_MODE, {junk[31:3], mode_code});
        write_reg(REG_LRATE, c.lrate);
        write_reg(REG_COEFF, c.coeff);
        write_reg(REG_OFFSET_B, c.offset_b);
        write_reg(REG_DECAY_RATE, {junk[31], c.decay_rate});
        write_reg(REG_LOWER_BOUND, c.lower_bound);
        write_reg(REG_UPPER_BOUND, c.upper_bound);
        write_reg(REG_CLAMP_ENABLE, {junk[31:1], c.clamp_enable});
    endtask

    // Output side: check each accepted transaction, then redraw the stall.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                checker_h.check_result(out_data);
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    initial begin
        int sent;
        int run_len;
        checker_h         = new();
        sender_idle_pct   = 28;
        receiver_idle_pct = 52;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: zero step leaves even the extreme elements alone.
        send_element(S32_MAX, S32_MIN, $urandom(), 1'b0);
        send_element(S32_MIN, S32_MAX, S32_MIN, 1'b1);

        // Scaled step on the reset coefficient of one; the second sum saturates.
        wait_drained();
        write_reg(REG_MODE, MODE_SCALED);
        write_reg(REG_LRATE, Q_ONE);
        send_element(Q_ONE, 32'sh0002_8000, '0, 1'b0);
        send_element(S32_MAX, S32_MAX, S32_MAX, 1'b1);

        // Most negative step with a tight box: clip low, clip high, then inside.
        wait_drained();
        write_reg(REG_MODE, MODE_STEP);
        write_reg(REG_LRATE, S32_MIN);
        write_reg(REG_LOWER_BOUND, -Q_ONE);
        write_reg(REG_UPPER_BOUND, Q_ONE);
        write_reg(REG_CLAMP_ENABLE, 1'b1);
        send_element('0, S32_MAX, '0, 1'b0);
        send_element('0, S32_MIN, '0, 1'b0);
        send_element('0, '0, '0, 1'b1);

        // L1 decay: the absolute value of the most negative step saturates, and
        // decay is never clamped even with the box enabled.
        wait_drained();
        write_reg(REG_MODE, MODE_L1);
        write_reg(REG_DECAY_RATE, 32'h7FFF_FFFF);
        send_element(S32_MIN, '0, '0, 1'b0);
        send_element(32'sd5, 32'sd1, '0, 1'b0);
        // Soft threshold at one half: inside, on the edge, above and below.
        wait_drained();
        write_reg(REG_LRATE, 32'sh0000_8000);
        write_reg(REG_DECAY_RATE, Q_ONE);
        send_element(32'sh0000_4000, Q_ONE, '0, 1'b0);
        send_element(32'sh0000_8000, Q_ONE, '0, 1'b0);
        send_element(32'sh0002_0000, Q_ONE, '0, 1'b0);
        send_element(-32'sh0002_0000, -Q_ONE, '0, 1'b1);

        // L2 decay with the largest decay.
        wait_drained();
        write_reg(REG_MODE, MODE_L2);
        write_reg(REG_LRATE, 32'sh0000_1000);
        write_reg(REG_DECAY_RATE, 32'h7FFF_FFFF);
        send_element(S32_MAX, S32_MIN, '0, 1'b0);
        send_element(-32'sh0003_0000, Q_ONE, '0, 1'b1);

        // Set with crossed bounds: the lower bound is tested first and wins below it.
        wait_drained();
        write_reg(REG_MODE, MODE_SET);
        write_reg(REG_LOWER_BOUND, Q_ONE);
        write_reg(REG_UPPER_BOUND, -Q_ONE);
        send_element($urandom(), '0, '0, 1'b0);
        send_element($urandom(), 32'sh0005_0000, '0, 1'b1);

        // Add with the box at the full range: saturation lands on the bound.
        wait_drained();
        write_reg(REG_MODE, MODE_ADD);
        write_reg(REG_LOWER_BOUND, S32_MIN);
        write_reg(REG_UPPER_BOUND, S32_MAX);
        send_element(S32_MAX, 32'sd1, '0, 1'b1);

        // Per-element step with extreme coefficient and offset, no clamp.
        wait_drained();
        write_reg(REG_MODE, MODE_ELEM);
        write_reg(REG_COEFF, S32_MIN);
        write_reg(REG_OFFSET_B, S32_MAX);
        write_reg(REG_CLAMP_ENABLE, 1'b0);
        send_element(Q_ONE, Q_ONE, Q_ONE, 1'b0);
        send_element(-Q_ONE, Q_ONE, -Q_ONE, 1'b1);

        // Unused mode code passes the element through, unclipped.
        wait_drained();
        write_reg(REG_MODE, MODE_UNUSED);
        write_reg(REG_CLAMP_ENABLE, 1'b1);
        write_reg(REG_UPPER_BOUND, '0);
        send_element(S32_MAX, S32_MIN, '0, 1'b1);

        // Random vectors. Each segment drains, loads fresh registers and streams
        // runs that end on a last element; the segments sweep all mode codes in
        // each of the three idle profiles.
        for (int seg = 0; seg < 24; seg++) begin
            if (seg == 8) begin
                sender_idle_pct   = 52;
                receiver_idle_pct = 28;
            end
            if (seg == 16) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            wait_drained();
            load_config(3'(seg % 8), rand_config());
            sent = 0;
            while (sent < 42) begin
                run_len = $urandom_range(1, 12);
                for (int k = 0; k < run_len; k++)
                    send_element(rand_q(), rand_q(), rand_q(), k == run_len - 1);
                sent += run_len;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (checker_h.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
sv/bcgu_pkg.sv
sv/bcgu_front.sv
sv/bcgu_back.sv
sv/bcgu_out.sv
sv/box_clamped_gradient_update_top.sv
sv/bcgu_checker.sv
bench/tb.sv
